// ===== rtl/pcfx_pkg.sv =====
`timescale 1ns / 1ps

package pcfx_pkg;

    localparam int PIX_W  = 8;
    localparam int CH_NUM = 3;

    // Configuration register indexes.
    localparam int       CFG_IDX_W  = 1;
    localparam logic     CFG_MODE   = 1'b0;
    localparam logic     CFG_THRESH = 1'b1;
    localparam int       MODE_W     = 3;

    localparam logic [MODE_W-1:0] MODE_GRAY   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_SEPIA  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_NEG    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_THRESH = 3'd3;
    localparam logic [MODE_W-1:0] MODE_DOM    = 3'd4;

    localparam logic [PIX_W-1:0] THRESH_RESET = 8'd100;
    localparam logic [PIX_W-1:0] PIX_MAX      = 8'd255;

    // Operation class decided by the front end.
    localparam int OP_W = 3;
    localparam logic [OP_W-1:0] OP_PASS   = 3'd0;
    localparam logic [OP_W-1:0] OP_GRAY   = 3'd1;
    localparam logic [OP_W-1:0] OP_SEPIA  = 3'd2;
    localparam logic [OP_W-1:0] OP_NEG    = 3'd3;
    localparam logic [OP_W-1:0] OP_THRESH = 3'd4;
    localparam logic [OP_W-1:0] OP_DOM    = 3'd5;

    // BT.709 luma weights in Q0.16.
    localparam int LUMA_ACC_W = 24;
    localparam logic [15:0] LUMA_COEF_R = 16'd13933;
    localparam logic [15:0] LUMA_COEF_G = 16'd46872;
    localparam logic [15:0] LUMA_COEF_B = 16'd4732;

    // Reciprocal floor(2^RECIP_SHIFT / d) and the sepia numerator widths.
    localparam int RECIP_SHIFT = 24;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam int NUM_W       = 16;
    localparam int PROD_W      = NUM_W + RECIP_W;

    localparam int MID_DEPTH_DEF = 4;
    localparam int OUT_DEPTH_DEF = 8;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
        logic [PIX_W-1:0] luma;
        logic             below;
        logic             frame_end;
    } t_work;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
        logic             frame_end;
    } t_pixel;

    function automatic logic [PIX_W-1:0] sepia_tone(input int ch);
        logic [PIX_W-1:0] tone;
        case (ch)
            0: tone = 8'd94;
            1: tone = 8'd38;
            default: tone = 8'd18;
        endcase
        return tone;
    endfunction

endpackage

// ===== rtl/pcfx_fifo.sv =====
`timescale 1ns / 1ps

module pcfx_fifo #(
    parameter int DEPTH = 4,
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_pop;

    // Writers never push into a full queue; the credit counters upstream see to that.
    assign do_pop  = i_pop && (r_count != '0);
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        n_count = r_count + CNT_W'(i_push) - CNT_W'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ===== rtl/pcfx_recip.sv =====
`timescale 1ns / 1ps

module pcfx_recip import pcfx_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [PIX_W-1:0]   i_den,
    output logic               o_busy,
    output logic [RECIP_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(RECIP_W);

    logic               r_busy;
    logic [CNT_W-1:0]   r_cnt;
    logic [PIX_W-1:0]   r_rem;
    logic [PIX_W-1:0]   r_den;
    logic [RECIP_W-1:0] r_quot;
    logic [PIX_W:0]     trial;
    logic               ge;

    // Restoring division of 2^RECIP_SHIFT: the dividend has a single one in its top bit.
    assign trial  = {r_rem, (r_cnt == '0)};
    assign ge     = (trial >= {1'b0, r_den});
    assign o_busy = r_busy;
    assign o_quot = r_quot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            if (r_cnt == CNT_W'(RECIP_W - 1)) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_den  <= i_den;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= ge ? PIX_W'(trial - {1'b0, r_den}) : trial[PIX_W-1:0];
            r_quot <= {r_quot[RECIP_W-2:0], ge};
        end
    end

endmodule

// ===== rtl/pcfx_front.sv =====
`timescale 1ns / 1ps

module pcfx_front import pcfx_pkg::*; #(
    parameter int MID_DEPTH = MID_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [PIX_W-1:0]  i_red_in,
    input  logic [PIX_W-1:0]  i_green_in,
    input  logic [PIX_W-1:0]  i_blue_in,
    input  logic              i_frame_end_in,
    input  logic [MODE_W-1:0] i_effect_mode,
    input  logic [PIX_W-1:0]  i_luma_threshold,
    input  logic              i_hold,
    input  logic              i_mid_pop,
    output logic              o_full,
    output logic              o_work_valid,
    output t_work             o_work
);

    localparam int USED_W = $clog2(MID_DEPTH + 1);

    logic [USED_W-1:0]     r_used, n_used;
    logic                  accept;

    logic                  r_s1_valid;
    logic [LUMA_ACC_W-1:0] r_s1_prod_r, r_s1_prod_g, r_s1_prod_b;
    logic [PIX_W-1:0]      r_s1_red, r_s1_green, r_s1_blue;
    logic                  r_s1_frame_end;

    logic [LUMA_ACC_W-1:0] luma_acc;
    logic [PIX_W-1:0]      luma;
    logic [OP_W-1:0]       op;
    logic                  r_s2_valid;
    t_work                 r_s2_work;

    // Each request holds a place in the middle queue from acceptance until the back end takes it.
    assign o_full = (r_used == USED_W'(MID_DEPTH)) || i_hold;
    assign accept = i_push && !o_full;
    assign n_used = r_used + USED_W'(accept) - USED_W'(i_mid_pop);

    assign luma_acc = r_s1_prod_r + r_s1_prod_g + r_s1_prod_b;
    assign luma     = luma_acc[LUMA_ACC_W-1 -: PIX_W];

    always_comb begin
        case (i_effect_mode)
            MODE_GRAY:   op = OP_GRAY;
            MODE_SEPIA:  op = OP_SEPIA;
            MODE_NEG:    op = OP_NEG;
            MODE_THRESH: op = OP_THRESH;
            MODE_DOM:    op = OP_DOM;
            default:     op = OP_PASS;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used     <= '0;
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_used     <= n_used;
            r_s1_valid <= accept;
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_prod_r    <= LUMA_ACC_W'(i_red_in) * LUMA_ACC_W'(LUMA_COEF_R);
        r_s1_prod_g    <= LUMA_ACC_W'(i_green_in) * LUMA_ACC_W'(LUMA_COEF_G);
        r_s1_prod_b    <= LUMA_ACC_W'(i_blue_in) * LUMA_ACC_W'(LUMA_COEF_B);
        r_s1_red       <= i_red_in;
        r_s1_green     <= i_green_in;
        r_s1_blue      <= i_blue_in;
        r_s1_frame_end <= i_frame_end_in;

        r_s2_work.op        <= op;
        r_s2_work.red       <= r_s1_red;
        r_s2_work.green     <= r_s1_green;
        r_s2_work.blue      <= r_s1_blue;
        r_s2_work.luma      <= luma;
        r_s2_work.below     <= (luma < i_luma_threshold);
        r_s2_work.frame_end <= r_s1_frame_end;
    end

    assign o_work_valid = r_s2_valid;
    assign o_work       = r_s2_work;

endmodule

// ===== rtl/pcfx_back.sv =====
`timescale 1ns / 1ps

module pcfx_back import pcfx_pkg::*; #(
    parameter int OUT_DEPTH = OUT_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_work_empty,
    input  t_work              i_work,
    output logic               o_work_pop,
    input  logic [PIX_W-1:0]   i_luma_threshold,
    input  logic [RECIP_W-1:0] i_recip_lo,
    input  logic [RECIP_W-1:0] i_recip_hi,
    input  logic               i_out_pop,
    output logic               o_res_valid,
    output t_pixel             o_res
);

    localparam int USED_W = $clog2(OUT_DEPTH + 1);

    logic [USED_W-1:0]  r_used, n_used;
    logic               issue;

    logic [PIX_W-1:0]   chan [CH_NUM];
    logic [PIX_W-1:0]   direct [CH_NUM];
    logic [NUM_W-1:0]   num [CH_NUM];
    logic [PIX_W-1:0]   base [CH_NUM];
    logic [PIX_W-1:0]   tone;
    logic [PIX_W-1:0]   den;
    logic               dom_r, dom_g, dom_b;

    // Stage 1: numerators, divisor and reciprocal selected.
    logic               r_b1_valid, r_b1_sepia, r_b1_frame_end;
    logic [NUM_W-1:0]   r_b1_num [CH_NUM];
    logic [PIX_W-1:0]   r_b1_base [CH_NUM];
    logic [PIX_W-1:0]   r_b1_direct [CH_NUM];
    logic [PIX_W-1:0]   r_b1_den;
    logic [RECIP_W-1:0] r_b1_recip;

    // Stage 2: numerator times reciprocal.
    logic               r_b2_valid, r_b2_sepia, r_b2_frame_end;
    logic [PROD_W-1:0]  r_b2_prod [CH_NUM];
    logic [NUM_W-1:0]   r_b2_num [CH_NUM];
    logic [PIX_W-1:0]   r_b2_base [CH_NUM];
    logic [PIX_W-1:0]   r_b2_direct [CH_NUM];
    logic [PIX_W-1:0]   r_b2_den;

    // Stage 3: quotient estimate and its back-product.
    logic               r_b3_valid, r_b3_sepia, r_b3_frame_end;
    logic [PIX_W-1:0]   r_b3_quot [CH_NUM];
    logic [NUM_W-1:0]   r_b3_qd [CH_NUM];
    logic [NUM_W-1:0]   r_b3_num [CH_NUM];
    logic [PIX_W-1:0]   r_b3_base [CH_NUM];
    logic [PIX_W-1:0]   r_b3_direct [CH_NUM];
    logic [PIX_W-1:0]   r_b3_den;

    // Stage 4: correction and final selection.
    logic [NUM_W-1:0]   rem [CH_NUM];
    logic [PIX_W-1:0]   quot [CH_NUM];
    logic [PIX_W-1:0]   final_ch [CH_NUM];
    logic               r_b4_valid;
    t_pixel             r_b4_pix;

    // A request is taken only when a place in the output queue is reserved for its result.
    assign issue      = !i_work_empty && (r_used != USED_W'(OUT_DEPTH));
    assign o_work_pop = issue;
    assign n_used     = r_used + USED_W'(issue) - USED_W'(i_out_pop);

    assign chan[0] = i_work.red;
    assign chan[1] = i_work.green;
    assign chan[2] = i_work.blue;

    assign dom_r = (chan[0] > chan[1]) && (chan[0] > chan[2]);
    assign dom_g = (chan[1] > chan[0]) && (chan[1] > chan[2]);
    assign dom_b = (chan[2] > chan[0]) && (chan[2] > chan[1]);

    assign den = i_work.below ? i_luma_threshold : PIX_MAX - i_luma_threshold;

    always_comb begin
        tone = '0;
        for (int i = 0; i < CH_NUM; i++) begin
            tone = sepia_tone(i);
            if (i_work.below) begin
                num[i]  = NUM_W'(tone) * NUM_W'(i_work.luma);
                base[i] = '0;
            end else begin
                num[i]  = NUM_W'(PIX_MAX - tone) * NUM_W'(PIX_W'(i_work.luma - i_luma_threshold));
                base[i] = tone;
            end
            case (i_work.op)
                OP_GRAY:   direct[i] = i_work.luma;
                OP_NEG:    direct[i] = ~chan[i];
                OP_THRESH: direct[i] = i_work.below ? PIX_MAX : '0;
                OP_DOM: begin
                    if (dom_r || dom_g || dom_b) begin
                        direct[i] = ((i == 0 && dom_r) || (i == 1 && dom_g) ||
                                     (i == 2 && dom_b)) ? PIX_MAX : '0;
                    end else begin
                        direct[i] = chan[i];
                    end
                end
                default:   direct[i] = chan[i];
            endcase
        end
    end

    always_comb begin
        for (int i = 0; i < CH_NUM; i++) begin
            rem[i]  = r_b3_num[i] - r_b3_qd[i];
            quot[i] = r_b3_quot[i] +
                      PIX_W'((r_b3_den != '0) && (rem[i] >= NUM_W'(r_b3_den)));
            final_ch[i] = r_b3_sepia ? PIX_W'(r_b3_base[i] + quot[i]) : r_b3_direct[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used     <= '0;
            r_b1_valid <= 1'b0;
            r_b2_valid <= 1'b0;
            r_b3_valid <= 1'b0;
            r_b4_valid <= 1'b0;
        end else begin
            r_used     <= n_used;
            r_b1_valid <= issue;
            r_b2_valid <= r_b1_valid;
            r_b3_valid <= r_b2_valid;
            r_b4_valid <= r_b3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b1_sepia     <= (i_work.op == OP_SEPIA);
        r_b1_frame_end <= i_work.frame_end;
        r_b1_den       <= den;
        r_b1_recip     <= i_work.below ? i_recip_lo : i_recip_hi;

        r_b2_sepia     <= r_b1_sepia;
        r_b2_frame_end <= r_b1_frame_end;
        r_b2_den       <= r_b1_den;

        r_b3_sepia     <= r_b2_sepia;
        r_b3_frame_end <= r_b2_frame_end;
        r_b3_den       <= r_b2_den;

        for (int i = 0; i < CH_NUM; i++) begin
            r_b1_num[i]    <= num[i];
            r_b1_base[i]   <= base[i];
            r_b1_direct[i] <= direct[i];

            r_b2_prod[i]   <= PROD_W'(r_b1_num[i]) * PROD_W'(r_b1_recip);
            r_b2_num[i]    <= r_b1_num[i];
            r_b2_base[i]   <= r_b1_base[i];
            r_b2_direct[i] <= r_b1_direct[i];

            // The estimate is never above the true quotient and at most one below it.
            r_b3_quot[i]   <= r_b2_prod[i][RECIP_SHIFT +: PIX_W];
            r_b3_qd[i]     <= NUM_W'(r_b2_prod[i][RECIP_SHIFT +: PIX_W]) * NUM_W'(r_b2_den);
            r_b3_num[i]    <= r_b2_num[i];
            r_b3_base[i]   <= r_b2_base[i];
            r_b3_direct[i] <= r_b2_direct[i];
        end

        r_b4_pix.red       <= final_ch[0];
        r_b4_pix.green     <= final_ch[1];
        r_b4_pix.blue      <= final_ch[2];
        r_b4_pix.frame_end <= r_b3_frame_end;
    end

    assign o_res_valid = r_b4_valid;
    assign o_res       = r_b4_pix;

endmodule

// ===== rtl/pixel_color_effect_unit.sv =====
`timescale 1ns / 1ps

// Color effect unit for 8-bit RGB pixels: grayscale, sepia, negative, threshold and
// dominant-channel, chosen by the mode register. Both sides behave as queues. The
// unit sustains one pixel per clock while full is low; a pushed pixel passes through
// the two-stage luma front end, the middle queue, the four-stage sepia divide
// pipeline and the output queue. Sepia divides by the threshold through reciprocals
// that two bit-serial dividers compute, one bit per cycle over 25 bits: after reset
// and after every write of the threshold register, full stays high until both
// dividers are done. Configuration registers should only be written while no pixels
// are in flight.
module pixel_color_effect_unit import pcfx_pkg::*; #(
    parameter int MID_DEPTH = MID_DEPTH_DEF,
    parameter int OUT_DEPTH = OUT_DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic [PIX_W-1:0]     i_red_in,
    input  logic [PIX_W-1:0]     i_green_in,
    input  logic [PIX_W-1:0]     i_blue_in,
    input  logic                 i_frame_end_in,
    output logic                 empty,
    input  logic                 pop,
    output logic [PIX_W-1:0]     o_red_out,
    output logic [PIX_W-1:0]     o_green_out,
    output logic [PIX_W-1:0]     o_blue_out,
    output logic                 o_frame_end_out,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [PIX_W-1:0]     i_cfg_data
);

    logic [MODE_W-1:0]  r_effect_mode;
    logic [PIX_W-1:0]   r_luma_threshold;
    logic               r_recip_go;
    logic               thresh_wr;
    logic               recip_start;
    logic [PIX_W-1:0]   den_lo, den_hi;
    logic               busy_lo, busy_hi;
    logic               recip_hold;
    logic [RECIP_W-1:0] recip_lo, recip_hi;

    logic               work_valid, work_pop, work_empty;
    t_work              work_in, work_out;
    logic               res_valid;
    t_pixel             res_in, res_out;
    logic               out_empty;

    assign thresh_wr   = i_cfg_we && (i_cfg_index == CFG_THRESH);
    assign recip_start = r_recip_go || thresh_wr;
    assign den_lo      = thresh_wr ? i_cfg_data : r_luma_threshold;
    assign den_hi      = PIX_MAX - den_lo;
    assign recip_hold  = r_recip_go || busy_lo || busy_hi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_effect_mode    <= MODE_GRAY;
            r_luma_threshold <= THRESH_RESET;
            r_recip_go       <= 1'b1;
        end else begin
            r_recip_go <= 1'b0;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_MODE:   r_effect_mode    <= i_cfg_data[MODE_W-1:0];
                    CFG_THRESH: r_luma_threshold <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    pcfx_recip u_recip_lo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (recip_start),
        .i_den   (den_lo),
        .o_busy  (busy_lo),
        .o_quot  (recip_lo)
    );

    pcfx_recip u_recip_hi (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (recip_start),
        .i_den   (den_hi),
        .o_busy  (busy_hi),
        .o_quot  (recip_hi)
    );

    pcfx_front #(
        .MID_DEPTH (MID_DEPTH)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_push           (push),
        .i_red_in         (i_red_in),
        .i_green_in       (i_green_in),
        .i_blue_in        (i_blue_in),
        .i_frame_end_in   (i_frame_end_in),
        .i_effect_mode    (r_effect_mode),
        .i_luma_threshold (r_luma_threshold),
        .i_hold           (recip_hold),
        .i_mid_pop        (work_pop),
        .o_full           (full),
        .o_work_valid     (work_valid),
        .o_work           (work_in)
    );

    pcfx_fifo #(
        .DEPTH (MID_DEPTH),
        .WIDTH ($bits(t_work))
    ) u_mid_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (work_valid),
        .i_data  (work_in),
        .i_pop   (work_pop),
        .o_empty (work_empty),
        .o_data  (work_out)
    );

    pcfx_back #(
        .OUT_DEPTH (OUT_DEPTH)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_work_empty     (work_empty),
        .i_work           (work_out),
        .o_work_pop       (work_pop),
        .i_luma_threshold (r_luma_threshold),
        .i_recip_lo       (recip_lo),
        .i_recip_hi       (recip_hi),
        .i_out_pop        (pop && !out_empty),
        .o_res_valid      (res_valid),
        .o_res            (res_in)
    );

    pcfx_fifo #(
        .DEPTH (OUT_DEPTH),
        .WIDTH ($bits(t_pixel))
    ) u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_data  (res_in),
        .i_pop   (pop),
        .o_empty (out_empty),
        .o_data  (res_out)
    );

    assign empty           = out_empty;
    assign o_red_out       = res_out.red;
    assign o_green_out     = res_out.green;
    assign o_blue_out      = res_out.blue;
    assign o_frame_end_out = res_out.frame_end;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import pcfx_pkg::*;

    // Mode codes that the block does not implement; a pixel passes through unchanged.
    localparam logic [MODE_W-1:0] MODE_SPARE_5 = 3'd5;
    localparam logic [MODE_W-1:0] MODE_SPARE_6 = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE_7 = 3'd7;

    localparam int unsigned Q16_R      = 13933;
    localparam int unsigned Q16_G      = 46872;
    localparam int unsigned Q16_B      = 4732;
    localparam int unsigned TONE_R     = 94;
    localparam int unsigned TONE_G     = 38;
    localparam int unsigned TONE_B     = 18;
    localparam int unsigned FULL_SCALE = 255;

    localparam int SETTLE_CYCLES  = 12;
    localparam int RANDOM_SEGS    = 15;
    localparam int SEG_PIXELS     = 60;
    localparam int TAIL_CYCLES    = 20;

    typedef enum logic [1:0] {
        JOB_PIXEL,
        JOB_SETTLE,
        JOB_WRITE
    } t_job_kind;

    typedef struct {
        t_job_kind              kind;
        t_pixel                 pix;
        logic [CFG_IDX_W-1:0]   idx;
        logic [PIX_W-1:0]       data;
    } t_job;

    logic                 i_clk           = 1'b0;
    logic                 i_rst_n         = 1'b0;
    logic                 push            = 1'b0;
    logic                 full;
    logic [PIX_W-1:0]     i_red_in        = '0;
    logic [PIX_W-1:0]     i_green_in      = '0;
    logic [PIX_W-1:0]     i_blue_in       = '0;
    logic                 i_frame_end_in  = 1'b0;
    logic                 empty;
    logic                 pop             = 1'b0;
    logic [PIX_W-1:0]     o_red_out;
    logic [PIX_W-1:0]     o_green_out;
    logic [PIX_W-1:0]     o_blue_out;
    logic                 o_frame_end_out;
    logic                 i_cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index     = '0;
    logic [PIX_W-1:0]     i_cfg_data      = '0;

    t_job   job_q[$];
    t_pixel pix_expect_q[$];

    logic [MODE_W-1:0] cur_mode   = MODE_GRAY;
    logic [PIX_W-1:0]  cur_thresh = THRESH_RESET;

    int accepted_cnt = 0;
    int popped_cnt   = 0;
    int settle_cnt   = 0;
    int err_cnt      = 0;

    pixel_color_effect_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_red_in        (i_red_in),
        .i_green_in      (i_green_in),
        .i_blue_in       (i_blue_in),
        .i_frame_end_in  (i_frame_end_in),
        .empty           (empty),
        .pop             (pop),
        .o_red_out       (o_red_out),
        .o_green_out     (o_green_out),
        .o_blue_out      (o_blue_out),
        .o_frame_end_out (o_frame_end_out),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic t_pixel effect_predict(input t_pixel px, input logic [MODE_W-1:0] mode,
                                              input logic [PIX_W-1:0] thr);
        int unsigned acc;
        int unsigned y;
        int unsigned t;
        int unsigned den;
        int unsigned num;
        int unsigned ch   [3];
        int unsigned res  [3];
        int unsigned tone [3];
        t_pixel      o;
        ch[0]   = px.red;
        ch[1]   = px.green;
        ch[2]   = px.blue;
        tone[0] = TONE_R;
        tone[1] = TONE_G;
        tone[2] = TONE_B;
        acc = Q16_R * ch[0] + Q16_G * ch[1] + Q16_B * ch[2];
        y   = acc >> 16;
        if (y > FULL_SCALE) y = FULL_SCALE;
        t = thr;
        for (int i = 0; i < 3; i++) res[i] = ch[i];
        case (mode)
            MODE_GRAY: begin
                for (int i = 0; i < 3; i++) res[i] = y;
            end
            MODE_SEPIA: begin
                for (int i = 0; i < 3; i++) begin
                    if (y < t) begin
                        res[i] = tone[i] * y / t;
                    end else begin
                        // Upper ramp toward white; a zero-length ramp leaves the tone.
                        den    = FULL_SCALE - t;
                        num    = (FULL_SCALE - tone[i]) * (y - t);
                        res[i] = tone[i] + ((den != 0) ? num / den : 0);
                    end
                end
            end
            MODE_NEG: begin
                for (int i = 0; i < 3; i++) res[i] = FULL_SCALE - ch[i];
            end
            MODE_THRESH: begin
                for (int i = 0; i < 3; i++) res[i] = (y < t) ? FULL_SCALE : 0;
            end
            MODE_DOM: begin
                for (int i = 0; i < 3; i++) begin
                    if (ch[i] > ch[(i + 1) % 3] && ch[i] > ch[(i + 2) % 3]) begin
                        res[i]           = FULL_SCALE;
                        res[(i + 1) % 3] = 0;
                        res[(i + 2) % 3] = 0;
                    end
                end
            end
            default: ;
        endcase
        o.red       = PIX_W'(res[0]);
        o.green     = PIX_W'(res[1]);
        o.blue      = PIX_W'(res[2]);
        o.frame_end = px.frame_end;
        return o;
    endfunction

    task automatic add_pixel(input int r, input int g, input int b, input logic fe);
        t_job j;
        j.kind            = JOB_PIXEL;
        j.pix.red         = PIX_W'(r);
        j.pix.green       = PIX_W'(g);
        j.pix.blue        = PIX_W'(b);
        j.pix.frame_end   = fe;
        j.idx             = '0;
        j.data            = '0;
        job_q.push_back(j);
    endtask

    // A register write always waits for the pipeline to empty first.
    task automatic add_write(input logic [CFG_IDX_W-1:0] idx, input logic [PIX_W-1:0] data);
        t_job j;
        j.kind = JOB_SETTLE;
        j.pix  = '0;
        j.idx  = '0;
        j.data = '0;
        job_q.push_back(j);
        j.kind = JOB_WRITE;
        j.idx  = idx;
        j.data = data;
        job_q.push_back(j);
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            err_cnt++;
        end
    endtask

    always @(posedge i_clk) begin : drive_proc
        logic nxt_push;
        logic nxt_we;
        int   send_idle;
        t_job job;
        if (!i_rst_n) begin
            push     <= 1'b0;
            i_cfg_we <= 1'b0;
        end else begin
            send_idle = (accepted_cnt < 300) ? 19 : (accepted_cnt < 600) ? 59 : 0;
            nxt_push  = push;
            nxt_we    = 1'b0;
            if (push && !full) begin
                pix_expect_q.push_back(effect_predict(
                    '{red: i_red_in, green: i_green_in, blue: i_blue_in,
                      frame_end: i_frame_end_in}, cur_mode, cur_thresh));
                accepted_cnt++;
                nxt_push = 1'b0;
            end
            if (!nxt_push) begin
                if (settle_cnt > 0) begin
                    settle_cnt--;
                end else if (job_q.size() > 0) begin
                    job = job_q[0];
                    case (job.kind)
                        JOB_PIXEL: begin
                            if ($urandom_range(99) >= send_idle) begin
                                i_red_in       <= job.pix.red;
                                i_green_in     <= job.pix.green;
                                i_blue_in      <= job.pix.blue;
                                i_frame_end_in <= job.pix.frame_end;
                                nxt_push = 1'b1;
                                job = job_q.pop_front();
                            end
                        end
                        JOB_SETTLE: begin
                            if (!push && pix_expect_q.size() == 0) begin
                                settle_cnt = SETTLE_CYCLES;
                                job = job_q.pop_front();
                            end
                        end
                        default: begin
                            i_cfg_index <= job.idx;
                            i_cfg_data  <= job.data;
                            nxt_we = 1'b1;
                            if (job.idx == CFG_MODE) cur_mode = job.data[MODE_W-1:0];
                            else cur_thresh = job.data;
                            job = job_q.pop_front();
                        end
                    endcase
                end
            end
            push     <= nxt_push;
            i_cfg_we <= nxt_we;
        end
    end

    always @(posedge i_clk) begin : monitor_proc
        int     recv_idle;
        t_pixel want;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            recv_idle = (popped_cnt < 300) ? 59 : (popped_cnt < 600) ? 19 : 0;
            if (pop && !empty) begin
                popped_cnt++;
                if (pix_expect_q.size() == 0) begin
                    $error("unexpected result: red %0d green %0d blue %0d frame_end %0d",
                           o_red_out, o_green_out, o_blue_out, o_frame_end_out);
                    err_cnt++;
                end else begin
                    want = pix_expect_q.pop_front();
                    check_field("red_out", want.red, o_red_out);
                    check_field("green_out", want.green, o_green_out);
                    check_field("blue_out", want.blue, o_blue_out);
                    check_field("frame_end_out", want.frame_end, o_frame_end_out);
                end
            end
            pop <= ($urandom_range(99) >= recv_idle);
        end
    end

    initial begin : stimulus_proc
        logic [MODE_W-1:0] mode_list [8];
        logic [MODE_W-1:0] md;
        logic [PIX_W-1:0]  d;
        int                thr;
        int                sel;
        int                a;
        int                b;
        int                v;
        int                pos;
        int                ch [3];

        mode_list[0] = MODE_GRAY;
        mode_list[1] = MODE_SEPIA;
        mode_list[2] = MODE_NEG;
        mode_list[3] = MODE_THRESH;
        mode_list[4] = MODE_DOM;
        mode_list[5] = MODE_SPARE_5;
        mode_list[6] = MODE_SPARE_6;
        mode_list[7] = MODE_SPARE_7;

        // Reset settings: grayscale with the default threshold.
        add_pixel(0, 0, 0, 1'b0);
        add_pixel(255, 255, 255, 1'b1);
        add_pixel(255, 0, 0, 1'b0);
        // Sepia just below, exactly at and far above the threshold.
        add_write(CFG_MODE, {5'b0, MODE_SEPIA});
        add_pixel(99, 99, 99, 1'b0);
        add_pixel(100, 100, 100, 1'b1);
        add_pixel(255, 255, 255, 1'b0);
        // Top threshold with full-scale luma leaves only the tone.
        add_write(CFG_THRESH, 8'd255);
        add_pixel(255, 255, 255, 1'b0);
        // Zero threshold: sepia runs on the upper ramp, binarization gives black.
        add_write(CFG_THRESH, 8'd0);
        add_pixel(0, 0, 0, 1'b0);
        add_write(CFG_MODE, {5'b0, MODE_THRESH});
        add_pixel(0, 0, 0, 1'b1);
        add_write(CFG_THRESH, THRESH_RESET);
        add_pixel(99, 99, 99, 1'b0);
        add_pixel(100, 100, 100, 1'b0);
        add_write(CFG_MODE, {5'b0, MODE_NEG});
        add_pixel(8'h5a, 8'ha5, 8'h0f, 1'b1);
        // Dominant channel, each color strictly largest, then ties.
        add_write(CFG_MODE, {5'b0, MODE_DOM});
        add_pixel(200, 10, 10, 1'b0);
        add_pixel(10, 200, 10, 1'b0);
        add_pixel(10, 10, 200, 1'b0);
        add_pixel(200, 200, 10, 1'b0);
        add_pixel(50, 50, 50, 1'b1);
        add_write(CFG_MODE, {5'b0, MODE_SPARE_6});
        add_pixel(1, 2, 3, 1'b0);

        for (int seg = 0; seg < RANDOM_SEGS; seg++) begin
            case (seg)
                0: thr = 1;
                1: thr = 254;
                2: thr = 0;
                3: thr = 255;
                4: thr = 128;
                default: thr = $urandom_range(254, 1);
            endcase
            md = (seg < 8) ? mode_list[seg] : mode_list[$urandom_range(4)];
            add_write(CFG_THRESH, PIX_W'(thr));
            // Upper data bits of the mode write are don't-care; exercise them too.
            d = PIX_W'($urandom);
            d[MODE_W-1:0] = md;
            add_write(CFG_MODE, d);
            for (int k = 0; k < SEG_PIXELS; k++) begin
                sel = $urandom_range(7);
                case (sel)
                    0: begin
                        v = $urandom_range(255);
                        ch[0] = v; ch[1] = v; ch[2] = v;
                    end
                    1: begin
                        a   = $urandom_range(255);
                        b   = $urandom_range(a);
                        pos = $urandom_range(2);
                        for (int i = 0; i < 3; i++) ch[i] = (i == pos) ? b : a;
                    end
                    2: begin
                        for (int i = 0; i < 3; i++) ch[i] = $urandom_range(1) ? 255 : 0;
                    end
                    3: begin
                        v = thr + $urandom_range(4) - 2;
                        if (v < 0) v = 0;
                        if (v > 255) v = 255;
                        ch[0] = v; ch[1] = v; ch[2] = v;
                    end
                    default: begin
                        for (int i = 0; i < 3; i++) ch[i] = $urandom_range(255);
                    end
                endcase
                add_pixel(ch[0], ch[1], ch[2], ($urandom_range(7) == 0));
            end
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do @(posedge i_clk);
        while (job_q.size() != 0 || push || pix_expect_q.size() != 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (err_cnt == 0 && pix_expect_q.size() == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

    initial begin : watchdog_proc
        #200000;
        $display("tb_top failed");
        $finish;
    end

endmodule
